/* rtl/core/fxalu_pkg.sv */
package fxalu_pkg;

  typedef enum logic [3:0] {
    ACT_ADD     = 4'd0,
    ACT_SUB     = 4'd1,
    ACT_MUL     = 4'd2,
    ACT_DIV     = 4'd3,
    ACT_MIN     = 4'd4,
    ACT_MAX     = 4'd5,
    ACT_INC     = 4'd6,
    ACT_DEC     = 4'd7,
    ACT_FROMINT = 4'd8,
    ACT_TOINT   = 4'd9
  } action_e;

  // Operation class picked by the front end.
  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2
  } class_e;

  localparam int unsigned DataW = 32;

  // Input beat.
  typedef struct packed {
    logic [3:0]        action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_beat_t;

  // Output beat.
  typedef struct packed {
    logic signed [31:0] result_value;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               divide_by_zero;
    logic               saturated;
  } out_beat_t;

endpackage

/* rtl/core/fxalu_if.sv */
interface fxalu_in_if;
  logic                valid;
  logic                ready;
  fxalu_pkg::in_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface fxalu_out_if;
  logic                 valid;
  logic                 ready;
  fxalu_pkg::out_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/fxalu_front.sv */
// Front end: classifies the action, computes compare flags and simple results.
module fxalu_front #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fxalu_pkg::in_beat_t in_beat_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output logic [1:0]          q_cls_o,
  output logic                q_neg_o,
  output logic [31:0]         q_ma_o,
  output logic [31:0]         q_mb_o,
  output fxalu_pkg::out_beat_t q_beat_o
);
  localparam int unsigned W = 34 + FRAC_BITS;

  logic signed [31:0] a, b;
  logic signed [W-1:0] ax, bx, sum;
  logic [3:0] act;
  logic signed [31:0] res;
  logic sat;
  logic [1:0] cls;
  logic valid_q;
  logic [1:0] cls_q;
  logic neg_q;
  logic [31:0] ma_q, mb_q;
  fxalu_pkg::out_beat_t beat_q;

  assign a   = in_beat_i.operand_a;
  assign b   = in_beat_i.operand_b;
  assign act = in_beat_i.action;
  assign ax  = W'(a);
  assign bx  = W'(b);

  // Simple-action datapath with clipping.
  always_comb begin
    sum = '0;
    res = '0;
    sat = 1'b0;
    cls = fxalu_pkg::CLS_SIMPLE;
    case (act)
      fxalu_pkg::ACT_ADD:     sum = ax + bx;
      fxalu_pkg::ACT_SUB:     sum = ax - bx;
      fxalu_pkg::ACT_INC:     sum = ax + W'(1);
      fxalu_pkg::ACT_DEC:     sum = ax - W'(1);
      fxalu_pkg::ACT_FROMINT: sum = ax <<< FRAC_BITS;
      fxalu_pkg::ACT_MIN:     sum = (a < b) ? ax : bx;
      fxalu_pkg::ACT_MAX:     sum = (a > b) ? ax : bx;
      fxalu_pkg::ACT_TOINT:   sum = ax >>> FRAC_BITS;
      fxalu_pkg::ACT_MUL:     cls = fxalu_pkg::CLS_MUL;
      fxalu_pkg::ACT_DIV:     cls = fxalu_pkg::CLS_DIV;
      default:                sum = '0;
    endcase
    if (sum > W'(64'sh7FFFFFFF)) begin
      res = 32'sh7FFFFFFF;
      sat = 1'b1;
    end else if (sum < -W'(64'sh80000000)) begin
      res = 32'sh80000000;
      sat = 1'b1;
    end else begin
      res = sum[31:0];
    end
  end

  // Output register; takes a beat whenever the slot is free or draining.
  assign in_ready_o = !valid_q || q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cls_q <= cls;
      neg_q <= a[31] ^ b[31];
      ma_q  <= a[31] ? 32'(-a) : a;
      mb_q  <= b[31] ? 32'(-b) : b;
      beat_q.result_value   <= res;
      beat_q.a_less         <= a < b;
      beat_q.a_equal        <= a == b;
      beat_q.a_greater      <= a > b;
      beat_q.divide_by_zero <= (cls == fxalu_pkg::CLS_DIV) && (b == '0);
      beat_q.saturated      <= sat;
    end
  end

  assign q_valid_o = valid_q;
  assign q_cls_o   = cls_q;
  assign q_neg_o   = neg_q;
  assign q_ma_o    = ma_q;
  assign q_mb_o    = mb_q;
  assign q_beat_o  = beat_q;
endmodule

/* rtl/core/fxalu_back.sv */
// Back end: pipelined multiply and restoring divide, one quotient bit per stage.
module fxalu_back #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  logic [1:0]           q_cls_i,
  input  logic                 q_neg_i,
  input  logic [31:0]          q_ma_i,
  input  logic [31:0]          q_mb_i,
  input  fxalu_pkg::out_beat_t q_beat_i,
  fxalu_out_if.source          out_o
);
  // Quotient of (2n+d)/(2d) with n = ma<<F: numerator width NW.
  localparam int unsigned NW = 34 + FRAC_BITS;
  localparam int unsigned DW = 33;
  localparam int unsigned NS = NW;
  // Magnitude width covers the full 64-bit product shifted down.
  localparam int unsigned SW = 65;

  typedef struct packed {
    logic [1:0]           cls;
    logic                 neg;
    logic [NW-1:0]        num;
    logic [DW:0]          rem;
    logic [DW-1:0]        den;
    logic [63:0]          prod;
    fxalu_pkg::out_beat_t beat;
  } stg_t;

  stg_t stg_q [NS+1];
  logic [NS:0] vld_q;
  logic adv;

  assign adv       = !vld_q[NS] || out_o.ready;
  assign q_ready_o = adv;

  // Stage chain; all stages move together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-1:0], q_valid_i};
    end
  end

  // Stage 0: load; multiply takes one 32x32 product.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q[0].cls  <= q_cls_i;
      stg_q[0].neg  <= q_neg_i;
      stg_q[0].num  <= (NW'(q_ma_i) << (FRAC_BITS + 1)) + NW'(q_mb_i);
      stg_q[0].rem  <= '0;
      stg_q[0].den  <= {q_mb_i, 1'b0};
      stg_q[0].prod <= q_ma_i * q_mb_i;
      stg_q[0].beat <= q_beat_i;
    end
  end

  // Divide stages: one quotient bit per stage.
  for (genvar s = 1; s <= NS; s++) begin : g_div
    logic [DW:0] trial;
    logic [DW+1:0] diff;
    assign trial = {stg_q[s-1].rem[DW-1:0], stg_q[s-1].num[NW-1]};
    assign diff  = {1'b0, trial} - {2'b0, stg_q[s-1].den};
    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[s].cls  <= stg_q[s-1].cls;
        stg_q[s].neg  <= stg_q[s-1].neg;
        stg_q[s].den  <= stg_q[s-1].den;
        stg_q[s].prod <= stg_q[s-1].prod;
        stg_q[s].beat <= stg_q[s-1].beat;
        stg_q[s].num  <= {stg_q[s-1].num[NW-2:0], !diff[DW+1]};
        stg_q[s].rem  <= diff[DW+1] ? trial : diff[DW:0];
      end
    end
  end

  // Final rounding, sign and clip.
  logic [SW-1:0] mag;
  logic [63:0] pr;
  logic signed [SW:0] sv;
  fxalu_pkg::out_beat_t ob;
  always_comb begin
    ob  = stg_q[NS].beat;
    pr  = stg_q[NS].prod + (64'd1 << (FRAC_BITS - 1));
    mag = '0;
    case (stg_q[NS].cls)
      fxalu_pkg::CLS_MUL: mag = SW'(pr >> FRAC_BITS);
      fxalu_pkg::CLS_DIV: mag = SW'(stg_q[NS].num);
      default:            mag = '0;
    endcase
    sv = stg_q[NS].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if ((stg_q[NS].cls == fxalu_pkg::CLS_MUL) ||
        (stg_q[NS].cls == fxalu_pkg::CLS_DIV && !ob.divide_by_zero)) begin
      if (sv > (SW+1)'(64'sh7FFFFFFF)) begin
        ob.result_value = 32'sh7FFFFFFF;
        ob.saturated    = 1'b1;
      end else if (sv < -(SW+1)'(64'sh80000000)) begin
        ob.result_value = 32'sh80000000;
        ob.saturated    = 1'b1;
      end else begin
        ob.result_value = sv[31:0];
      end
    end else if (stg_q[NS].cls == fxalu_pkg::CLS_DIV) begin
      ob.result_value = '0;
    end
  end

  assign out_o.valid   = vld_q[NS];
  assign out_o.payload = ob;
endmodule

/* rtl/core/fixed_point_q24_8_alu.sv */
// Channel | dir | handshake   | payload
// in_i    | in  | valid/ready | action, operand_a, operand_b
// out_o   | out | valid/ready | result_value, flags
//
// One beat accepted per cycle while out_o is not stalled; results pass the front
// register and the divider pipeline, one quotient bit per stage (multiply rides alongside).
// rst_ni clears all valid bits asynchronously; payload is not reset.
// A stalled output freezes the back pipeline; in_i.ready then drops as soon
// as the front register holds a beat.
module fixed_point_q24_8_alu #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fxalu_in_if.sink    in_i,
  fxalu_out_if.source out_o
);
  logic                 q_valid, q_ready, q_neg;
  logic [1:0]           q_cls;
  logic [31:0]          q_ma, q_mb;
  fxalu_pkg::out_beat_t q_beat;

  fxalu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready), .in_beat_i(in_i.payload),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cls_o(q_cls), .q_neg_o(q_neg),
    .q_ma_o(q_ma), .q_mb_o(q_mb), .q_beat_o(q_beat)
  );

  fxalu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cls_i(q_cls), .q_neg_i(q_neg),
    .q_ma_i(q_ma), .q_mb_i(q_mb), .q_beat_i(q_beat), .out_o(out_o)
  );
endmodule

/* rtl/core/fxalu_checker.sv */
module fxalu_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input fxalu_pkg::out_beat_t out_beat
);
  // Compare flags are mutually exclusive.
  a_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> $onehot({out_beat.a_less, out_beat.a_equal, out_beat.a_greater}))
    else $error("compare flags not one-hot");

  // Divide by zero never reports saturation and returns zero.
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_beat.divide_by_zero |->
      !out_beat.saturated && out_beat.result_value == '0)
    else $error("divide by zero result wrong");

  // Saturated results sit at a rail.
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_beat.saturated |->
      (out_beat.result_value == 32'sh7FFFFFFF || out_beat.result_value == 32'sh80000000))
    else $error("saturated result off rail");

  // Stalled output holds its beat.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("output beat dropped");

  // Input ready is always driven while a beat is offered.
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid |-> !$isunknown(in_ready))
    else $error("input ready unknown");
endmodule

bind fixed_point_q24_8_alu fxalu_checker u_checker (
  .clk_i, .rst_ni,
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_beat(out_o.payload)
);

/* tb/tb_fixed_point_q24_8_alu.sv */
`timescale 1ns / 1ps

module tb_fixed_point_q24_8_alu;

  localparam int unsigned FracBits   = 8;
  localparam int unsigned Latency    = FracBits + 35;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  fxalu_in_if  in_if ();
  fxalu_out_if out_if ();

  fixed_point_q24_8_alu #(.FRAC_BITS(FracBits)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  fxalu_pkg::out_beat_t alu_results_q[$];
  int unsigned n_errors = 0;
  int unsigned cycle_cnt = 0;
  // receiver stall control
  bit          stall_long = 1'b0;
  bit          rx_no_stall = 1'b0;

  // Golden ALU result for one operation.
  function automatic fxalu_pkg::out_beat_t alu_predict(logic [3:0] act,
                                                       logic signed [31:0] a,
                                                       logic signed [31:0] b);
    fxalu_pkg::out_beat_t r;
    longint       ax, bx, v;
    longint unsigned ma, mb, p, q, n;
    bit           neg;
    ax = a;
    bx = b;
    v = 0;
    r = '0;
    ma = (ax < 0) ? -ax : ax;
    mb = (bx < 0) ? -bx : bx;
    neg = (ax < 0) != (bx < 0);
    case (act)
      fxalu_pkg::ACT_ADD: v = ax + bx;
      fxalu_pkg::ACT_SUB: v = ax - bx;
      fxalu_pkg::ACT_MUL: begin
        p = ma * mb;
        q = (p + (64'd1 << (FracBits - 1))) >> FracBits;
        v = neg ? -longint'(q) : longint'(q);
      end
      fxalu_pkg::ACT_DIV: begin
        if (bx == 0) begin
          r.divide_by_zero = 1'b1;
          v = 0;
        end else begin
          n = ma << FracBits;
          q = (2 * n + mb) / (2 * mb);
          v = neg ? -longint'(q) : longint'(q);
        end
      end
      fxalu_pkg::ACT_MIN: v = (ax < bx) ? ax : bx;
      fxalu_pkg::ACT_MAX: v = (ax > bx) ? ax : bx;
      fxalu_pkg::ACT_INC: v = ax + 1;
      fxalu_pkg::ACT_DEC: v = ax - 1;
      fxalu_pkg::ACT_FROMINT: v = ax * (64'sd1 <<< FracBits);
      fxalu_pkg::ACT_TOINT: v = ax >>> FracBits;
      default: v = 0;
    endcase
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      r.saturated = 1'b1;
    end else if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      r.saturated = 1'b1;
    end
    r.result_value = v[31:0];
    r.a_less       = ax < bx;
    r.a_equal      = ax == bx;
    r.a_greater    = ax > bx;
    return r;
  endfunction

  // Drive one beat; burst gaps decided by caller via gap_max.
  task automatic send_op(logic [3:0] act, logic [31:0] a, logic [31:0] b, int gap_max);
    int gap;
    gap = (gap_max > 0 && $urandom_range(3) == 0) ? $urandom_range(gap_max) : 0;
    repeat (gap) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= '{action: act, operand_a: a, operand_b: b};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    alu_results_q.push_back(alu_predict(act, a, b));
    @(negedge clk_i);
  endtask

  task automatic idle_sender();
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_sender();
    while (alu_results_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(511);
      3: return -$urandom_range(511);
      4: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Directed: extremes, every action, special cases.
  task automatic test_directed();
    logic [31:0] ext[5];
    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h100, 32'hffff_ff00};
    send_op(fxalu_pkg::ACT_DIV, 32'h100, 32'h0, 0);          // divide by zero
    send_op(fxalu_pkg::ACT_INC, 32'h7fff_ffff, 32'h0, 0);    // inc at maximum
    send_op(fxalu_pkg::ACT_DEC, 32'h8000_0000, 32'h0, 0);    // dec at minimum
    send_op(fxalu_pkg::ACT_MUL, 32'h8000_0000, 32'h8000_0000, 0);
    send_op(fxalu_pkg::ACT_DIV, 32'h8000_0000, 32'h1, 0);
    send_op(fxalu_pkg::ACT_DIV, 32'h180, 32'h200, 0);         // fractional quotient (1.5 / 2.0)
    send_op(fxalu_pkg::ACT_MUL, 32'hffff_ff80, 32'h1, 0);
    send_op(4'd10, 32'h5, 32'h5, 0);
    send_op(4'd15, 32'hffff_ffff, 32'h0, 0);
    send_op(fxalu_pkg::ACT_TOINT, 32'hffff_ff01, 32'h0, 0);
    send_op(fxalu_pkg::ACT_FROMINT, 32'h0080_0000, 32'h0, 0);
    send_op(fxalu_pkg::ACT_ADD, 32'h7fff_ffff, 32'h1, 0);
    send_op(fxalu_pkg::ACT_SUB, 32'h8000_0000, 32'h1, 0);
    for (int i = 0; i < 10; i++) begin
      send_op(4'(i), ext[i % 5], ext[(i + 2) % 5], 0);
    end
  endtask

  // Random: all actions with weighted operand classes, bursty sender.
  task automatic test_random(int count);
    logic [3:0] act;
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
      send_op(act, rand_operand(), ($urandom_range(9) == 0) ? 32'h0 : rand_operand(), 6);
    end
  endtask

  // Receiver held off for a long stretch while items keep coming.
  task automatic test_backpressure();
    stall_long = 1'b1;
    test_random(120);
    stall_long = 1'b0;
  endtask

  // No idling on either side.
  task automatic test_full_rate();
    rx_no_stall = 1'b1;
    for (int i = 0; i < 60; i++) begin
      send_op(4'($urandom_range(9)), rand_operand(), rand_operand(), 0);
    end
    rx_no_stall = 1'b0;
  endtask

  // Receiver stall pattern
  initial begin
    int held;
    out_if.ready = 1'b0;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (stall_long && held < 300) begin
        out_if.ready <= 1'b0;
        held++;
      end else begin
        if (!stall_long) held = 0;
        out_if.ready <= rx_no_stall || ((cycle_cnt / 37) % 4 == 0) || $urandom_range(3) != 0;
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    fxalu_pkg::out_beat_t want, got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (alu_results_q.size() == 0) begin
        $error("unexpected result beat %h", got);
        n_errors++;
      end else begin
        want = alu_results_q.pop_front();
        if (got.result_value !== want.result_value) begin
          $error("result_value exp %h got %h", want.result_value, got.result_value);
          n_errors++;
        end
        if (got.a_less !== want.a_less) begin
          $error("a_less exp %b got %b", want.a_less, got.a_less);
          n_errors++;
        end
        if (got.a_equal !== want.a_equal) begin
          $error("a_equal exp %b got %b", want.a_equal, got.a_equal);
          n_errors++;
        end
        if (got.a_greater !== want.a_greater) begin
          $error("a_greater exp %b got %b", want.a_greater, got.a_greater);
          n_errors++;
        end
        if (got.divide_by_zero !== want.divide_by_zero) begin
          $error("divide_by_zero exp %b got %b", want.divide_by_zero, got.divide_by_zero);
          n_errors++;
        end
        if (got.saturated !== want.saturated) begin
          $error("saturated exp %b got %b", want.saturated, got.saturated);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    wait_drained();     // sender pause until all results are back
    test_random(250);
    test_backpressure();
    test_full_rate();
    wait_drained();
    repeat (Latency + 10) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/fxalu_pkg.sv
rtl/core/fxalu_if.sv
rtl/core/fxalu_front.sv
rtl/core/fxalu_back.sv
rtl/core/fixed_point_q24_8_alu.sv
rtl/core/fxalu_checker.sv
tb/tb_fixed_point_q24_8_alu.sv
